### hdl/lcsuc_pkg.sv
// ---------------------------------------------------------------------------
// lcsuc_pkg
// Shared types and constants for the LCS unmatched-count block.
// ---------------------------------------------------------------------------
package lcsuc_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned CharW         = 8;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned OutW          = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_APP_TYPED  = 2'd1,
    CMD_APP_TARGET = 2'd2,
    CMD_COMPUTE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } state_e;

endpackage

### hdl/lcsuc_cell.sv
// ---------------------------------------------------------------------------
// lcsuc_cell
// One LCS dynamic-programming cell: match gives diagonal plus one, otherwise
// the larger of the above and left scores.
// ---------------------------------------------------------------------------
module lcsuc_cell #(
  parameter int unsigned LW = 7
) (
  input  logic [lcsuc_pkg::CharW-1:0] typed_char_i,
  input  logic [lcsuc_pkg::CharW-1:0] target_char_i,
  input  logic                        first_row_i,
  input  logic [LW-1:0]               above_raw_i,
  input  logic [LW-1:0]               left_i,
  input  logic [LW-1:0]               diag_i,
  output logic [LW-1:0]               above_o,
  output logic [LW-1:0]               val_o
);

  // the score row is never cleared: the first row sees zeros above
  assign above_o = first_row_i ? '0 : above_raw_i;

  always_comb begin
    if (typed_char_i == target_char_i) begin
      val_o = diag_i + LW'(1);
    end else if (above_o > left_i) begin
      val_o = above_o;
    end else begin
      val_o = left_i;
    end
  end

endmodule

### hdl/lcs_unmatched_count.sv
// ---------------------------------------------------------------------------
// lcs_unmatched_count
// Longest common subsequence length of a typed and a target word, and the
// count of typed characters left unmatched.
// ---------------------------------------------------------------------------
// Clear and append commands never raise in_stall_o. A compute command keeps
// in_stall_o high until its result is moved to the output register (straight
// through ST_DONE when either word is empty), which waits while an earlier
// result is still held at the output: a single DP cell walks the score row one
// entry per cycle through the row memory, with an ST_ROW step per target row
// to fetch the target character. The result waits in an output register, so
// loads for the next word pair are taken while it is still stalled.
module lcs_unmatched_count #(
  parameter int unsigned MAX_LEN = lcsuc_pkg::MaxLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lcsuc_pkg::CmdW-1:0]  command_i,
  input  logic [lcsuc_pkg::CharW-1:0] char_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lcsuc_pkg::OutW-1:0]  common_length_o,
  output logic [lcsuc_pkg::OutW-1:0]  unmatched_count_o,
  output logic                        overflowed_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = lcsuc_pkg::CharW;

  lcsuc_pkg::state_e state_q, state_d;

  logic [LW-1:0] typed_len_q, typed_len_d;
  logic [LW-1:0] target_len_q, target_len_d;
  logic          dropped_q, dropped_d;
  logic [AW-1:0] row_q, row_d;
  logic [LW-1:0] col_q, col_d;
  logic [LW-1:0] left_q, left_d;
  logic [LW-1:0] diag_q, diag_d;
  logic          first_row_q, first_row_d;
  logic [LW-1:0] common_q, common_d;

  logic                              out_valid_q, out_valid_d;
  logic [lcsuc_pkg::OutW-1:0]        common_out_q, common_out_d;
  logic [lcsuc_pkg::OutW-1:0]        unmatched_q, unmatched_d;
  logic                              ovf_q, ovf_d;

  // memories
  logic [CW-1:0] typed_mem  [MAX_LEN];
  logic [CW-1:0] target_mem [MAX_LEN];
  logic [LW-1:0] score_mem  [MAX_LEN+1];

  logic          typed_we, target_we, score_we, target_re;
  logic [AW-1:0] typed_waddr, target_waddr, typed_raddr, target_raddr;
  logic [LW-1:0] score_waddr, score_raddr, score_wdata;
  logic [CW-1:0] typed_rd_q, target_rd_q;
  logic [LW-1:0] score_rd_q;

  logic [LW-1:0] above, cell_val;
  logic          in_xfer;

  lcsuc_cell #(.LW(LW)) u_cell (
    .typed_char_i  (typed_rd_q),
    .target_char_i (target_rd_q),
    .first_row_i   (first_row_q),
    .above_raw_i   (score_rd_q),
    .left_i        (left_q),
    .diag_i        (diag_q),
    .above_o       (above),
    .val_o         (cell_val)
  );

  assign in_stall_o = (state_q != lcsuc_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (typed_we) begin
      typed_mem[typed_waddr] <= char_code_i;
    end
    if (target_we) begin
      target_mem[target_waddr] <= char_code_i;
    end
    if (score_we) begin
      score_mem[score_waddr] <= score_wdata;
    end
    typed_rd_q <= typed_mem[typed_raddr];
    score_rd_q <= score_mem[score_raddr];
    if (target_re) begin
      target_rd_q <= target_mem[target_raddr];
    end
  end

  always_comb begin
    state_d      = state_q;
    typed_len_d  = typed_len_q;
    target_len_d = target_len_q;
    dropped_d    = dropped_q;
    row_d        = row_q;
    col_d        = col_q;
    left_d       = left_q;
    diag_d       = diag_q;
    first_row_d  = first_row_q;
    common_d     = common_q;
    out_valid_d  = out_valid_q && out_stall_i;
    common_out_d = common_out_q;
    unmatched_d  = unmatched_q;
    ovf_d        = ovf_q;

    typed_we     = 1'b0;
    target_we    = 1'b0;
    score_we     = 1'b0;
    target_re    = 1'b0;
    typed_waddr  = typed_len_q[AW-1:0];
    target_waddr = target_len_q[AW-1:0];
    typed_raddr  = col_q[AW-1:0];
    target_raddr = row_q;
    score_waddr  = col_q;
    score_raddr  = col_q + LW'(1);
    score_wdata  = cell_val;

    case (state_q)
      lcsuc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (lcsuc_pkg::cmd_e'(command_i))
            lcsuc_pkg::CMD_CLEAR: begin
              typed_len_d  = '0;
              target_len_d = '0;
              dropped_d    = 1'b0;
            end
            lcsuc_pkg::CMD_APP_TYPED: begin
              if (typed_len_q < LW'(MAX_LEN)) begin
                typed_we    = 1'b1;
                typed_len_d = typed_len_q + LW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            lcsuc_pkg::CMD_APP_TARGET: begin
              if (target_len_q < LW'(MAX_LEN)) begin
                target_we    = 1'b1;
                target_len_d = target_len_q + LW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            lcsuc_pkg::CMD_COMPUTE: begin
              row_d       = '0;
              first_row_d = 1'b1;
              common_d    = '0;
              if ((typed_len_q == '0) || (target_len_q == '0)) begin
                state_d = lcsuc_pkg::ST_DONE;
              end else begin
                state_d = lcsuc_pkg::ST_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      lcsuc_pkg::ST_ROW: begin
        // fetch target char, first typed char and score entry 1
        target_re   = 1'b1;
        typed_raddr = '0;
        score_raddr = LW'(1);
        left_d      = '0;
        diag_d      = '0;
        col_d       = LW'(1);
        state_d     = lcsuc_pkg::ST_CELL;
      end
      lcsuc_pkg::ST_CELL: begin
        score_we = 1'b1;
        left_d   = cell_val;
        diag_d   = above;
        if (col_q == typed_len_q) begin
          if ((LW'(row_q) + LW'(1)) == target_len_q) begin
            common_d = cell_val;
            state_d  = lcsuc_pkg::ST_DONE;
          end else begin
            row_d       = row_q + AW'(1);
            first_row_d = 1'b0;
            state_d     = lcsuc_pkg::ST_ROW;
          end
        end else begin
          col_d = col_q + LW'(1);
        end
      end
      lcsuc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          common_out_d = lcsuc_pkg::OutW'(common_q);
          unmatched_d  = lcsuc_pkg::OutW'(typed_len_q - common_q);
          ovf_d        = dropped_q;
          state_d      = lcsuc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcsuc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lcsuc_pkg::ST_IDLE;
      typed_len_q  <= '0;
      target_len_q <= '0;
      dropped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      typed_len_q  <= typed_len_d;
      target_len_q <= target_len_d;
      dropped_q    <= dropped_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    col_q        <= col_d;
    left_q       <= left_d;
    diag_q       <= diag_d;
    first_row_q  <= first_row_d;
    common_q     <= common_d;
    common_out_q <= common_out_d;
    unmatched_q  <= unmatched_d;
    ovf_q        <= ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign common_length_o   = common_out_q;
  assign unmatched_count_o = unmatched_q;
  assign overflowed_o      = ovf_q;

endmodule

### hdl/lcsuc_checker.sv
// ---------------------------------------------------------------------------
// lcsuc_checker
// Port-level checks for the LCS unmatched-count block, bound to the top level.
// ---------------------------------------------------------------------------
module lcsuc_checker #(
  parameter int unsigned MAX_LEN = lcsuc_pkg::MaxLenDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [lcsuc_pkg::CmdW-1:0]  command_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lcsuc_pkg::OutW-1:0]  common_length_o,
  input logic [lcsuc_pkg::OutW-1:0]  unmatched_count_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(common_length_o) && $stable(unmatched_count_o))
    else $error("stalled result changed");

  // a compute transfer always makes the block go busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == lcsuc_pkg::CMD_COMPUTE) |=> in_stall_o)
    else $error("compute accepted without going busy");

  // matched plus unmatched is the typed length, never above the word limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MAX_LEN >= 128) ||
      ((8'(common_length_o) + 8'(unmatched_count_o)) <= 8'(MAX_LEN)))
    else $error("result exceeds word limit");

endmodule

bind lcs_unmatched_count lcsuc_checker #(.MAX_LEN(MAX_LEN)) u_lcsuc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .command_i         (command_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .common_length_o   (common_length_o),
  .unmatched_count_o (unmatched_count_o)
);

### bench/lcs_unmatched_count_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcs_unmatched_count_test
// Self-checking bench for the LCS unmatched-count block. A short directed
// sequence goes first, then random clear/load/compute runs, most of them
// small and a few loading both words to near or past their capacity. Both channels
// idle and stall at random. Every result is compared with a behavioural LCS
// predictor kept in step with the accepted transfers.
// ---------------------------------------------------------------------------
module lcs_unmatched_count_test;

  localparam int unsigned MaxLen = lcsuc_pkg::MaxLenDefault;
  localparam int unsigned CharW  = lcsuc_pkg::CharW;
  localparam int unsigned CmdW   = lcsuc_pkg::CmdW;
  localparam int unsigned OutW   = lcsuc_pkg::OutW;

  typedef struct packed {
    logic [OutW-1:0] common_len;
    logic [OutW-1:0] unmatched;
    logic            overflow;
  } score_t;

  typedef struct {
    lcsuc_pkg::cmd_e  cmd;
    logic [CharW-1:0] ch;
    bit               fixed;
    score_t           want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CmdW-1:0]   command_i;
  logic [CharW-1:0]  char_code_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [OutW-1:0]   common_length_o;
  logic [OutW-1:0]   unmatched_count_o;
  logic              overflowed_o;

  // Predictor state
  logic [CharW-1:0]  typed_word [MaxLen];
  logic [CharW-1:0]  target_word [MaxLen];
  int unsigned       typed_len;
  int unsigned       target_len;
  logic              dropped;

  score_t            expected_scores [$];
  int unsigned       error_count;
  int unsigned       items_sent;
  int unsigned       computes_sent;
  int unsigned       feed_quiet;
  int unsigned       sink_quiet;

  // Fixed expectations only where they are obvious: empty words, after reset.
  stim_row_t directed_rows [20] = '{
    '{lcsuc_pkg::CMD_COMPUTE,    8'h00, 1'b1, '{7'd0, 7'd0, 1'b0}},
    '{lcsuc_pkg::CMD_APP_TYPED,  8'h00, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TYPED,  8'hff, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'hff, 1'b1, '{7'd0, 7'd2, 1'b0}},
    '{lcsuc_pkg::CMD_APP_TARGET, 8'hff, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TARGET, 8'h00, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'h00, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TARGET, 8'h00, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'h55, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'haa, 1'b0, '0},
    '{lcsuc_pkg::CMD_CLEAR,      8'hff, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TARGET, 8'ha5, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'h00, 1'b1, '{7'd0, 7'd0, 1'b0}},
    '{lcsuc_pkg::CMD_APP_TYPED,  8'h5a, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TYPED,  8'ha5, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TYPED,  8'h5a, 1'b0, '0},
    '{lcsuc_pkg::CMD_APP_TARGET, 8'h5a, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'h00, 1'b0, '0},
    '{lcsuc_pkg::CMD_CLEAR,      8'h00, 1'b0, '0},
    '{lcsuc_pkg::CMD_COMPUTE,    8'hff, 1'b1, '{7'd0, 7'd0, 1'b0}}
  };

  lcs_unmatched_count #(
    .MAX_LEN(MaxLen)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .common_length_o  (common_length_o),
    .unmatched_count_o(unmatched_count_o),
    .overflowed_o     (overflowed_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Random wait before a transfer, with occasional runs of back-to-back transfers.
  function automatic int unsigned draw_wait(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Row-by-row DP over the target word.
  function automatic score_t predict_score();
    int unsigned row [MaxLen + 1];
    int unsigned diag;
    int unsigned above;
    score_t      s;
    for (int unsigned j = 0; j <= typed_len; j++) row[j] = 0;
    for (int unsigned r = 0; r < target_len; r++) begin
      diag = 0;
      for (int unsigned j = 1; j <= typed_len; j++) begin
        above = row[j];
        if (typed_word[j-1] == target_word[r]) begin
          row[j] = diag + 1;
        end else begin
          row[j] = (above > row[j-1]) ? above : row[j-1];
        end
        diag = above;
      end
    end
    s.common_len = OutW'(row[typed_len]);
    s.unmatched  = OutW'(typed_len - row[typed_len]);
    s.overflow   = dropped;
    return s;
  endfunction

  function automatic void apply_transfer(lcsuc_pkg::cmd_e cmd, logic [CharW-1:0] ch,
                                         bit fixed, score_t want);
    case (cmd)
      lcsuc_pkg::CMD_CLEAR: begin
        typed_len  = 0;
        target_len = 0;
        dropped    = 1'b0;
      end
      lcsuc_pkg::CMD_APP_TYPED: begin
        if (typed_len < MaxLen) begin
          typed_word[typed_len] = ch;
          typed_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      lcsuc_pkg::CMD_APP_TARGET: begin
        if (target_len < MaxLen) begin
          target_word[target_len] = ch;
          target_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      lcsuc_pkg::CMD_COMPUTE: begin
        expected_scores.insert(expected_scores.size(), fixed ? want : predict_score());
        computes_sent++;
      end
      default: ;
    endcase
  endfunction

  // Valid stays high after a transfer; it is only lowered for a gap.
  task automatic send_item(input lcsuc_pkg::cmd_e cmd, input logic [CharW-1:0] ch,
                           input bit fixed = 1'b0, input score_t want = '0);
    int unsigned gap;
    gap = draw_wait(feed_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    char_code_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    apply_transfer(cmd, ch, fixed, want);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_scores.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CharW-1:0] pick_char(bit narrow);
    return narrow ? CharW'(8'h61 + $urandom_range(0, 3)) : CharW'($urandom_range(0, 255));
  endfunction

  initial begin : feed
    int unsigned n_typed;
    int unsigned n_target;
    bit          narrow;
    bit          first_run;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    command_i   <= lcsuc_pkg::CMD_CLEAR;
    char_code_i <= '0;
    typed_len   = 0;
    target_len  = 0;
    dropped     = 1'b0;
    error_count = 0;
    items_sent  = 0;
    computes_sent = 0;
    feed_quiet  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].fixed,
                directed_rows[i].want);
    end
    drain_results();

    // First random run loads 60 to 70 characters into each word so the full-word drop can show up early.
    first_run = 1'b1;
    while (items_sent < 1000 || computes_sent < 40) begin
      if (!first_run && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(lcsuc_pkg::cmd_e'($urandom_range(0, 3)), CharW'($urandom_range(0, 255)));
        end
      end else begin
        if (first_run || $urandom_range(0, 3) != 0) begin
          send_item(lcsuc_pkg::CMD_CLEAR, CharW'($urandom_range(0, 255)));
        end
        if (first_run || $urandom_range(0, 15) == 0) begin
          n_typed  = $urandom_range(60, 70);
          n_target = $urandom_range(60, 70);
        end else begin
          n_typed  = $urandom_range(0, 10);
          n_target = $urandom_range(0, 10);
        end
        first_run = 1'b0;
        narrow = ($urandom_range(0, 2) != 0);
        while (n_typed + n_target > 0) begin
          if (n_target == 0 || (n_typed > 0 && $urandom_range(0, 1) == 1)) begin
            send_item(lcsuc_pkg::CMD_APP_TYPED, pick_char(narrow));
            n_typed--;
          end else begin
            send_item(lcsuc_pkg::CMD_APP_TARGET, pick_char(narrow));
            n_target--;
          end
        end
        repeat ($urandom_range(1, 2)) begin
          send_item(lcsuc_pkg::CMD_COMPUTE, CharW'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) == 0) drain_results();
      end
    end

    drain_results();
    // room for any stray result from a full-size compute
    repeat (4200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : sink
    int unsigned hold;
    score_t      want;
    out_stall_i <= 1'b0;
    sink_quiet  = 0;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait(sink_quiet);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_scores.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transfer: common %0d unmatched %0d overflowed %0b",
                 $time, common_length_o, unmatched_count_o, overflowed_o);
      end else begin
        want = expected_scores.pop_front();
        if (common_length_o !== want.common_len) begin
          error_count++;
          $display("%0t: common_length expected %0d, got %0d",
                   $time, want.common_len, common_length_o);
        end
        if (unmatched_count_o !== want.unmatched) begin
          error_count++;
          $display("%0t: unmatched_count expected %0d, got %0d",
                   $time, want.unmatched, unmatched_count_o);
        end
        if (overflowed_o !== want.overflow) begin
          error_count++;
          $display("%0t: overflowed expected %0b, got %0b",
                   $time, want.overflow, overflowed_o);
        end
      end
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
